[rtl/core/gal_pkg.sv]
package gal_pkg;

	localparam int VERTEX_W    = 5;
	localparam int COUNT_W     = 6;
	localparam int STATUS_W    = 2;
	localparam int MAX_RESULTS = 64;
	localparam int RESULT_CW   = $clog2(MAX_RESULTS);

	typedef logic [VERTEX_W-1:0] vertex_t;
	typedef logic [COUNT_W-1:0]  count_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_QUERY  = 1'b1
	} kind_t;

endpackage

[rtl/core/gal_ifs.sv]
interface gal_req_if
	import gal_pkg::*;
();
	logic    valid;
	logic    ready;
	kind_t   kind;
	vertex_t from_vertex;
	vertex_t to_vertex;

	modport source (output valid, output kind, output from_vertex, output to_vertex,
		input ready);
	modport sink (input valid, input kind, input from_vertex, input to_vertex,
		output ready);
endinterface

interface gal_rsp_if
	import gal_pkg::*;
();
	logic    valid;
	logic    ready;
	status_t status;
	vertex_t neighbor;
	logic    last;

	modport source (output valid, output status, output neighbor, output last,
		input ready);
	modport sink (input valid, input status, input neighbor, input last,
		output ready);
endinterface

interface gal_cfg_if
	import gal_pkg::*;
();
	logic   valid;
	logic   ready;
	count_t vertex_count;

	modport source (output valid, output vertex_count, input ready);
	modport sink (input valid, input vertex_count, output ready);
endinterface

[rtl/core/gal_ram.sv]
module gal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/graph_adjacency_list_store.sv]
// Channel  Modport  Payload                              Transaction when
// req      sink     kind, from_vertex, to_vertex          req.valid && req.ready
// rsp      source   status, neighbor, last                rsp.valid && rsp.ready
// cfg      sink     vertex_count                          cfg.valid && cfg.ready
//
// An insert, a rejected query or a query of an empty list reads the list head, then
// updates the memories (inserts only) and loads the result register.
// A query walks its list one node per cycle while the result register is free, through
// the edge memory read port, and returns at most 64 neighbors.
// A full result register holds the head stage and the walk in place until rsp takes it.
// Reset clears the list heads through per-vertex valid flags; no clearing pass runs.
module graph_adjacency_list_store
	import gal_pkg::*;
#(
	parameter int MAX_VERTICES = 32,
	parameter int EDGE_SLOTS   = 64
) (
	input logic      clk,
	input logic      arst_n,
	gal_req_if.sink   req,
	gal_rsp_if.source rsp,
	gal_cfg_if.sink   cfg
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int AW = $clog2(EDGE_SLOTS);
	localparam int SW = $clog2(EDGE_SLOTS + 1);
	localparam int EW = VERTEX_W + SW;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_HEAD = 3'b010,
		S_WALK = 3'b100
	} state_t;

	state_t               state_q;
	count_t               vertex_count_q;
	logic [SW-1:0]        free_q;
	logic [MAX_VERTICES-1:0] hvld_q;
	kind_t                kind_q;
	logic [VW-1:0]        from_idx_q;
	vertex_t              to_q;
	logic                 ok_q;
	logic [AW-1:0]        cur_q;
	logic [RESULT_CW-1:0] cnt_q;

	logic                 out_vld_q;
	status_t              out_status_q;
	vertex_t              out_nb_q;
	logic                 out_last_q;

	logic                 accept;
	logic                 out_free;
	logic                 from_ok;
	logic                 to_ok;
	logic [VW-1:0]        req_idx;
	logic [VW-1:0]        head_raddr;
	logic [SW-1:0]        head_rdata;
	logic [SW-1:0]        head;
	logic                 head_we;
	logic [SW-1:0]        head_wdata;
	logic                 edge_we;
	logic [AW-1:0]        edge_waddr;
	logic [EW-1:0]        edge_wdata;
	logic [AW-1:0]        edge_raddr;
	logic [EW-1:0]        edge_rdata;
	vertex_t              edge_target;
	logic [SW-1:0]        edge_next;
	logic                 pool_full;
	logic                 walk_last;
	logic                 emit;
	status_t              emit_status;
	vertex_t              emit_nb;
	logic                 emit_last;
	state_t               state_d;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free  = !out_vld_q || rsp.ready;

	assign from_ok = ({1'b0, req.from_vertex} < vertex_count_q)
		&& (32'(req.from_vertex) < MAX_VERTICES);
	assign to_ok   = ({1'b0, req.to_vertex} < vertex_count_q)
		&& (32'(req.to_vertex) < MAX_VERTICES);
	assign req_idx = VW'(req.from_vertex);

	assign head_raddr = (state_q == S_IDLE) ? req_idx : from_idx_q;
	assign head       = (ok_q && hvld_q[from_idx_q]) ? head_rdata : '0;
	assign pool_full  = (free_q == SW'(EDGE_SLOTS));

	assign edge_target = edge_rdata[EW-1:SW];
	assign edge_next   = edge_rdata[SW-1:0];
	assign walk_last   = (edge_next == '0) || (cnt_q == RESULT_CW'(MAX_RESULTS - 1));

	assign head_we    = (state_q == S_HEAD) && out_free && (kind_q == KIND_INSERT)
		&& ok_q && !pool_full;
	assign head_wdata = free_q + SW'(1);
	assign edge_we    = head_we;
	assign edge_waddr = AW'(free_q);
	assign edge_wdata = {to_q, head};

	always_comb begin
		edge_raddr  = cur_q;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_nb     = '0;
		emit_last   = 1'b1;
		state_d     = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				edge_raddr = AW'(head - SW'(1));
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (!ok_q) begin
						emit_status = ST_RANGE;
					end else if (kind_q == KIND_INSERT) begin
						emit_status = pool_full ? ST_FULL : ST_OK;
					end else if (head == '0) begin
						emit_status = ST_EMPTY;
					end else begin
						emit    = 1'b0;
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_nb   = edge_target;
					emit_last = walk_last;
					if (walk_last) begin
						state_d = S_IDLE;
					end else begin
						edge_raddr = AW'(edge_next - SW'(1));
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			vertex_count_q <= '0;
			free_q         <= '0;
			hvld_q         <= '0;
			out_vld_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				vertex_count_q <= cfg.vertex_count;
			end
			if (head_we) begin
				free_q             <= free_q + SW'(1);
				hvld_q[from_idx_q] <= 1'b1;
			end
			out_vld_q <= emit || (out_vld_q && !rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= req.kind;
			from_idx_q <= req_idx;
			to_q       <= req.to_vertex;
			ok_q       <= from_ok && ((req.kind == KIND_QUERY) || to_ok);
		end
		if (state_q == S_HEAD) begin
			cnt_q <= '0;
			cur_q <= edge_raddr;
		end else if (state_q == S_WALK && emit && !walk_last) begin
			cnt_q <= cnt_q + RESULT_CW'(1);
			cur_q <= edge_raddr;
		end
		if (emit) begin
			out_status_q <= emit_status;
			out_nb_q     <= emit_nb;
			out_last_q   <= emit_last;
		end
	end

	assign rsp.valid    = out_vld_q;
	assign rsp.status   = out_status_q;
	assign rsp.neighbor = out_nb_q;
	assign rsp.last     = out_last_q;

	gal_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_VERTICES)
	) u_head_ram (
		.clk  (clk),
		.we   (head_we),
		.waddr(from_idx_q),
		.wdata(head_wdata),
		.raddr(head_raddr),
		.rdata(head_rdata)
	);

	gal_ram #(
		.WIDTH(EW),
		.DEPTH(EDGE_SLOTS)
	) u_edge_ram (
		.clk  (clk),
		.we   (edge_we),
		.waddr(edge_waddr),
		.wdata(edge_wdata),
		.raddr(edge_raddr),
		.rdata(edge_rdata)
	);

	a_fail_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> rsp.last)
		else $error("non-ok result without last");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(free_q) <= EDGE_SLOTS)
		else $error("edge pool count beyond pool size");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		head_we |-> !pool_full)
		else $error("edge insert into full pool");

	a_accept_to_head: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_HEAD))
		else $error("accepted transaction did not reach the head stage");

endmodule

[verif/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gal_pkg::*;

	localparam int GRAPH_VERTICES = 32;
	localparam int POOL_SLOTS     = 64;
	localparam int CYCLE_LIMIT    = 300000;
	localparam int PRINT_LIMIT    = 20;

	typedef struct packed {
		kind_t   kind;
		vertex_t from_v;
		vertex_t to_v;
	} graph_req_t;

	typedef struct packed {
		status_t status;
		vertex_t neighbor;
		logic    last;
	} graph_rsp_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	gal_req_if req_if();
	gal_rsp_if rsp_if();
	gal_cfg_if cfg_if();

	graph_adjacency_list_store #(
		.MAX_VERTICES(GRAPH_VERTICES),
		.EDGE_SLOTS  (POOL_SLOTS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if),
		.cfg   (cfg_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the graph, updated as each request transaction is accepted.
	logic [6:0] shadow_head [GRAPH_VERTICES];
	vertex_t    shadow_target [POOL_SLOTS];
	logic [6:0] shadow_next [POOL_SLOTS];
	int         slots_used;
	count_t     vertex_limit;

	graph_req_t pending_req [$];
	graph_rsp_t results_due [$];
	graph_req_t next_req;
	graph_rsp_t due_rsp;

	bit no_idle;
	int gap_left;
	int stall_left;
	int cycle_count;
	int errors;
	int items_accepted;
	int results_seen;
	int cfg_writes;
	int status_seen [4];

	function automatic bit vertex_ok(input vertex_t v);
		return (v < vertex_limit) && (v < GRAPH_VERTICES);
	endfunction

	task automatic apply_graph_request(input kind_t kind, input vertex_t from_v,
		input vertex_t to_v);
		logic [6:0] link;
		int         n;
		graph_rsp_t r;
		if (kind == KIND_INSERT) begin
			if (!vertex_ok(from_v) || !vertex_ok(to_v)) begin
				results_due.push_back(graph_rsp_t'{ST_RANGE, vertex_t'(0), 1'b1});
			end else if (slots_used >= POOL_SLOTS) begin
				results_due.push_back(graph_rsp_t'{ST_FULL, vertex_t'(0), 1'b1});
			end else begin
				shadow_target[slots_used] = to_v;
				shadow_next[slots_used] = shadow_head[from_v];
				shadow_head[from_v] = 7'(slots_used + 1);
				slots_used++;
				results_due.push_back(graph_rsp_t'{ST_OK, vertex_t'(0), 1'b1});
			end
		end else if (!vertex_ok(from_v)) begin
			results_due.push_back(graph_rsp_t'{ST_RANGE, vertex_t'(0), 1'b1});
		end else if (shadow_head[from_v] == 0) begin
			results_due.push_back(graph_rsp_t'{ST_EMPTY, vertex_t'(0), 1'b1});
		end else begin
			link = shadow_head[from_v];
			n = 0;
			while (link != 0 && n < MAX_RESULTS) begin
				r.status = ST_OK;
				r.neighbor = shadow_target[link - 1];
				link = shadow_next[link - 1];
				n++;
				r.last = (link == 0) || (n == MAX_RESULTS);
				results_due.push_back(r);
			end
		end
	endtask

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("mismatch at result %0d: %s", results_seen, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				apply_graph_request(req_if.kind, req_if.from_vertex, req_if.to_vertex);
				items_accepted++;
			end
			if (req_if.valid && !req_if.ready) begin
				// Hold the current transaction until it is taken.
			end else if (gap_left > 0) begin
				req_if.valid <= 1'b0;
				gap_left--;
			end else if (pending_req.size() != 0) begin
				next_req = pending_req.pop_front();
				req_if.valid <= 1'b1;
				req_if.kind <= next_req.kind;
				req_if.from_vertex <= next_req.from_v;
				req_if.to_vertex <= next_req.to_v;
				gap_left = no_idle ? 0 : $urandom_range(0, 4);
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				results_seen++;
				status_seen[rsp_if.status]++;
				if (results_due.size() == 0) begin
					report_mismatch($sformatf("unexpected status %0d neighbor %0d last %0d",
						rsp_if.status, rsp_if.neighbor, rsp_if.last));
				end else begin
					due_rsp = results_due.pop_front();
					if (rsp_if.status !== due_rsp.status)
						report_mismatch($sformatf("status %0d, want %0d",
							rsp_if.status, due_rsp.status));
					if (rsp_if.neighbor !== due_rsp.neighbor)
						report_mismatch($sformatf("neighbor %0d, want %0d",
							rsp_if.neighbor, due_rsp.neighbor));
					if (rsp_if.last !== due_rsp.last)
						report_mismatch($sformatf("last %0d, want %0d",
							rsp_if.last, due_rsp.last));
				end
				stall_left = no_idle ? 0 : $urandom_range(0, 4);
			end
			if (stall_left > 0) begin
				rsp_if.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				results_due.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic set_vertex_count(input count_t value);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.vertex_count <= value;
		do
			@(posedge clk);
		while (!(cfg_if.valid && cfg_if.ready));
		vertex_limit = value;
		cfg_writes++;
		cfg_if.valid <= 1'b0;
	endtask

	task automatic drain_graph_traffic();
		do
			@(negedge clk);
		while (pending_req.size() != 0 || req_if.valid || results_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic push_req(input kind_t kind, input vertex_t from_v, input vertex_t to_v);
		pending_req.push_back(graph_req_t'{kind, from_v, to_v});
	endtask

	function automatic vertex_t pick_vertex();
		int span;
		span = (vertex_limit > GRAPH_VERTICES) ? GRAPH_VERTICES : vertex_limit;
		if (span != 0 && $urandom_range(0, 99) < 85)
			return vertex_t'($urandom_range(0, span - 1));
		return vertex_t'($urandom_range(0, GRAPH_VERTICES - 1));
	endfunction

	task automatic push_random(input int count, input int insert_pct);
		repeat (count)
			push_req(($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_QUERY,
				pick_vertex(), pick_vertex());
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.kind = KIND_INSERT;
		req_if.from_vertex = '0;
		req_if.to_vertex = '0;
		cfg_if.valid = 1'b0;
		cfg_if.vertex_count = '0;
		rsp_if.ready = 1'b0;
		for (int i = 0; i < GRAPH_VERTICES; i++)
			shadow_head[i] = '0;
		slots_used = 0;
		vertex_limit = '0;
		no_idle = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		set_vertex_count(count_t'(0));
		push_req(KIND_INSERT, 5'd0, 5'd0);
		push_req(KIND_QUERY, 5'd0, 5'd0);
		push_req(KIND_QUERY, 5'd31, 5'd31);
		drain_graph_traffic();

		set_vertex_count(count_t'(63));
		push_req(KIND_INSERT, 5'd31, 5'd0);
		push_req(KIND_INSERT, 5'd31, 5'd31);
		push_req(KIND_INSERT, 5'd0, 5'd31);
		push_req(KIND_INSERT, 5'd0, 5'd0);
		push_req(KIND_QUERY, 5'd31, 5'd0);
		push_req(KIND_QUERY, 5'd0, 5'd31);
		push_req(KIND_QUERY, 5'd5, 5'd0);
		push_req(KIND_QUERY, 5'd30, 5'd31);
		drain_graph_traffic();

		set_vertex_count(count_t'(3));
		push_req(KIND_INSERT, 5'd31, 5'd0);
		push_req(KIND_INSERT, 5'd2, 5'd3);
		push_req(KIND_INSERT, 5'd2, 5'd2);
		push_req(KIND_QUERY, 5'd31, 5'd0);
		push_req(KIND_QUERY, 5'd0, 5'd0);
		push_req(KIND_QUERY, 5'd2, 5'd0);
		push_req(KIND_QUERY, 5'd1, 5'd0);
		drain_graph_traffic();

		for (int phase = 0; phase < 5; phase++) begin
			no_idle = (phase == 2);
			case (phase)
				0: set_vertex_count(count_t'(32));
				1: set_vertex_count(count_t'(2));
				2: set_vertex_count(count_t'($urandom_range(4, 31)));
				3: set_vertex_count(count_t'(63));
				default: set_vertex_count(count_t'(1));
			endcase
			push_random(10, 50);
			drain_graph_traffic();
		end
		no_idle = 1'b0;

		set_vertex_count(count_t'(32));
		repeat (POOL_SLOTS - slots_used)
			push_req(KIND_INSERT, pick_vertex(), pick_vertex());
		push_random(6, 50);
		drain_graph_traffic();

		set_vertex_count(count_t'($urandom_range(8, 24)));
		push_req(KIND_INSERT, 5'd31, 5'd0);
		push_random(6, 50);
		drain_graph_traffic();

		$display("%0d requests, %0d results: %0d ok, %0d out of range, %0d full, %0d empty",
			items_accepted, results_seen, status_seen[ST_OK], status_seen[ST_RANGE],
			status_seen[ST_FULL], status_seen[ST_EMPTY]);
		$display("%0d vertex count writes, %0d of %0d edge slots filled, %0d mismatches",
			cfg_writes, slots_used, POOL_SLOTS, errors);
		if (errors == 0 && results_due.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
